// ===== design/hte_pkg.sv =====
// Package for the two-locus haplotype EM block: widths, job record, control types.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package hte_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int FRAC_BITS   = 24;
  localparam int IN_W        = 16;
  localparam int HAP_W       = COUNT_BITS + 2;
  localparam int TOT_W       = COUNT_BITS + 5;
  localparam int SHARE_W     = FRAC_BITS + 1;
  localparam int T_W         = COUNT_BITS + FRAC_BITS;
  localparam int E_W         = COUNT_BITS + FRAC_BITS + 3;
  localparam int MUL_W       = (E_W + 1) / 2;
  localparam int MUL2_W      = 2 * MUL_W;
  localparam int PROD_W      = 2 * E_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int DIV_W       = SUM_W + FRAC_BITS;
  localparam int QBITS_W     = $clog2(SHARE_W + 1);
  localparam int FREQ_W      = 17;
  localparam int FREQ_SHIFT  = 16;
  localparam int LIMIT_W     = 10;
  localparam int TOL_W       = 24;
  localparam int TOL_SCALE   = 24;
  localparam int CMP_W       = SHARE_W + TOL_SCALE;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 24;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_HAP     = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);
  localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(17);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMIT = 1'b0,
    REG_TOL   = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T1,
    ST_EXP,
    ST_MUL,
    ST_SUM,
    ST_EDIV,
    ST_CHK,
    ST_FDIV,
    ST_RES
  } back_state_e;

  typedef struct packed {
    logic [HAP_W-1:0]      uu;
    logic [HAP_W-1:0]      ul;
    logic [HAP_W-1:0]      lu;
    logic [HAP_W-1:0]      ll;
    logic [COUNT_BITS-1:0] h;
    logic [TOT_W-1:0]      tot;
    logic                  empty;
  } job_t;

  typedef struct packed {
    logic               start;
    logic [QBITS_W-1:0] steps;
  } div_req_t;

  function automatic logic [COUNT_BITS-1:0] to_count(input logic [IN_W-1:0] v);
    logic [IN_W+COUNT_BITS-1:0] ext;
    ext = {{COUNT_BITS{1'b0}}, v};
    return ext[COUNT_BITS-1:0];
  endfunction

endpackage

// ===== design/hte_if.sv =====
// Channel interfaces of the haplotype EM block: count input, result output, register write.
// Depends on hte_pkg for field widths.
`timescale 1ns / 1ps

interface hte_in_if;
  logic                   valid;
  logic                   ready;
  logic [hte_pkg::IN_W-1:0] count_r0_c0;
  logic [hte_pkg::IN_W-1:0] count_r0_c1;
  logic [hte_pkg::IN_W-1:0] count_r0_c2;
  logic [hte_pkg::IN_W-1:0] count_r1_c0;
  logic [hte_pkg::IN_W-1:0] count_r1_c1;
  logic [hte_pkg::IN_W-1:0] count_r1_c2;
  logic [hte_pkg::IN_W-1:0] count_r2_c0;
  logic [hte_pkg::IN_W-1:0] count_r2_c1;
  logic [hte_pkg::IN_W-1:0] count_r2_c2;

  modport source (
    output valid, count_r0_c0, count_r0_c1, count_r0_c2, count_r1_c0, count_r1_c1,
           count_r1_c2, count_r2_c0, count_r2_c1, count_r2_c2,
    input  ready
  );
  modport sink (
    input  valid, count_r0_c0, count_r0_c1, count_r0_c2, count_r1_c0, count_r1_c1,
           count_r1_c2, count_r2_c0, count_r2_c1, count_r2_c2,
    output ready
  );
endinterface

interface hte_out_if;
  logic                       valid;
  logic                       ready;
  logic [hte_pkg::FREQ_W-1:0] freq_upper_upper;
  logic [hte_pkg::FREQ_W-1:0] freq_upper_lower;
  logic [hte_pkg::FREQ_W-1:0] freq_lower_upper;
  logic [hte_pkg::FREQ_W-1:0] freq_lower_lower;
  logic                       not_converged;
  logic                       empty_input;

  modport source (
    output valid, freq_upper_upper, freq_upper_lower, freq_lower_upper, freq_lower_lower,
           not_converged, empty_input,
    input  ready
  );
  modport sink (
    input  valid, freq_upper_upper, freq_upper_lower, freq_lower_upper, freq_lower_lower,
           not_converged, empty_input,
    output ready
  );
endinterface

interface hte_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hte_pkg::CFG_IDX_W-1:0]  index;
  logic [hte_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/hte_front.sv =====
// Front stage: accepts one word of nine genotype counts and forms the haplotype job.
// Depends on hte_pkg and hte_in_if.
`timescale 1ns / 1ps

module hte_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  hte_in_if.sink        in_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output hte_pkg::job_t job_o
);

  logic [hte_pkg::COUNT_BITS-1:0] c0, c1, c2, c3, c4, c5, c6, c7, c8;
  logic                           valid_q, valid_d;
  hte_pkg::job_t                  job_q, job_d;
  logic                           accept;

  assign in_i.ready  = !valid_q || job_ready_i;
  assign accept      = in_i.valid && in_i.ready;
  assign job_valid_o = valid_q;
  assign job_o       = job_q;

  always_comb begin
    c0 = hte_pkg::to_count(in_i.count_r0_c0);
    c1 = hte_pkg::to_count(in_i.count_r0_c1);
    c2 = hte_pkg::to_count(in_i.count_r0_c2);
    c3 = hte_pkg::to_count(in_i.count_r1_c0);
    c4 = hte_pkg::to_count(in_i.count_r1_c1);
    c5 = hte_pkg::to_count(in_i.count_r1_c2);
    c6 = hte_pkg::to_count(in_i.count_r2_c0);
    c7 = hte_pkg::to_count(in_i.count_r2_c1);
    c8 = hte_pkg::to_count(in_i.count_r2_c2);
    job_d.uu  = hte_pkg::HAP_W'({c0, 1'b0}) + hte_pkg::HAP_W'(c1) + hte_pkg::HAP_W'(c3);
    job_d.ul  = hte_pkg::HAP_W'({c2, 1'b0}) + hte_pkg::HAP_W'(c1) + hte_pkg::HAP_W'(c5);
    job_d.lu  = hte_pkg::HAP_W'({c6, 1'b0}) + hte_pkg::HAP_W'(c3) + hte_pkg::HAP_W'(c7);
    job_d.ll  = hte_pkg::HAP_W'({c8, 1'b0}) + hte_pkg::HAP_W'(c7) + hte_pkg::HAP_W'(c5);
    job_d.h   = c4;
    job_d.tot = hte_pkg::TOT_W'(job_d.uu) + hte_pkg::TOT_W'(job_d.ul)
              + hte_pkg::TOT_W'(job_d.lu) + hte_pkg::TOT_W'(job_d.ll)
              + hte_pkg::TOT_W'({c4, 1'b0});
    job_d.empty = (job_d.tot == '0);
  end

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (job_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

endmodule

// ===== design/hte_queue.sv =====
// Short job queue that decouples the front stage from the EM engine.
// Depends on hte_pkg for the job record and depth.
`timescale 1ns / 1ps

module hte_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  hte_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output hte_pkg::job_t pop_job_o
);

  hte_pkg::job_t               slot_q [hte_pkg::QUEUE_DEPTH];
  logic [hte_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [hte_pkg::QCNT_W-1:0]  cnt_q, cnt_d;
  logic                        push, pop;

  assign push_ready_o = (cnt_q != hte_pkg::QCNT_W'(hte_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == hte_pkg::QPTR_W'(hte_pkg::QUEUE_DEPTH - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == hte_pkg::QPTR_W'(hte_pkg::QUEUE_DEPTH - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== design/hte_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the EM step and the frequencies.
// Depends on hte_pkg; the caller supplies the divisor already aligned to the top quotient bit.
`timescale 1ns / 1ps

module hte_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hte_pkg::div_req_t           req_i,
  input  logic [hte_pkg::DIV_W-1:0]   num_i,
  input  logic [hte_pkg::DIV_W-1:0]   den_i,
  output logic                        done_o,
  output logic [hte_pkg::SHARE_W-1:0] quot_o
);

  logic                        busy_q, done_q;
  logic [hte_pkg::QBITS_W-1:0] cnt_q;
  logic [hte_pkg::DIV_W-1:0]   rem_q, dsh_q;
  logic [hte_pkg::SHARE_W-1:0] quot_q;
  logic                        ge;
  logic                        last;

  assign ge     = (rem_q >= dsh_q);
  assign last   = busy_q && (cnt_q == hte_pkg::QBITS_W'(1));
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= num_i;
      dsh_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[hte_pkg::SHARE_W-2:0], ge};
    end
  end

endmodule

// ===== design/hte_back.sv =====
// EM engine: sequencer with one shared partial-product multiplier and the shared divider,
// followed by the result register. Depends on hte_pkg, hte_div and hte_out_if.
`timescale 1ns / 1ps

module hte_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  output logic                        job_ready_o,
  input  hte_pkg::job_t               job_i,
  input  logic [hte_pkg::LIMIT_W-1:0] limit_i,
  input  logic [hte_pkg::TOL_W-1:0]   tol_i,
  hte_out_if.source                   out_o
);

  localparam int F = hte_pkg::FRAC_BITS;

  hte_pkg::back_state_e state_q, state_d;

  hte_pkg::job_t                  job_q;
  logic [hte_pkg::SHARE_W-1:0]    share_q, nxt_q;
  logic [hte_pkg::LIMIT_W-1:0]    iter_q;
  logic                           stuck_q, freq_ph_q;
  logic [hte_pkg::T_W-1:0]        t1_q, t2;
  logic [hte_pkg::E_W-1:0]        e_q [hte_pkg::NUM_HAP];
  logic [hte_pkg::E_W-1:0]        e_d [hte_pkg::NUM_HAP];
  logic                           mul_sel_q;
  logic [2:0]                     mcnt_q;
  logic [1:0]                     pidx;
  logic [hte_pkg::MUL2_W-1:0]     pp_q, pp_d, a_x, b_x;
  logic [hte_pkg::MUL_W-1:0]      a_part, b_part;
  logic [hte_pkg::PROD_W-1:0]     pp_ext, acc_add, acc_q, acc_d, cis_q;
  logic [hte_pkg::SUM_W-1:0]      sum;
  logic [1:0]                     fidx_q, fsel;
  logic [hte_pkg::E_W-1:0]        fnum;
  logic [hte_pkg::FREQ_W-1:0]     freq_q [hte_pkg::NUM_HAP];
  logic [hte_pkg::SHARE_W-1:0]    diff;
  logic                           conv, last_iter, mul_last;

  hte_pkg::div_req_t              div_req;
  logic [hte_pkg::DIV_W-1:0]      div_num, div_den;
  logic                           div_done;
  logic [hte_pkg::SHARE_W-1:0]    div_quot;

  logic                           pop, res_load, em_div;
  logic                           out_valid_q;
  logic [hte_pkg::FREQ_W-1:0]     out_freq_q [hte_pkg::NUM_HAP];
  logic                           out_stuck_q, out_empty_q;

  hte_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Datapath terms.
  always_comb begin
    t2 = hte_pkg::T_W'({job_q.h, {F{1'b0}}}) - t1_q;
    e_d[0] = hte_pkg::E_W'({job_q.uu, {F{1'b0}}}) + hte_pkg::E_W'(t1_q);
    e_d[1] = hte_pkg::E_W'({job_q.ul, {F{1'b0}}}) + hte_pkg::E_W'(t2);
    e_d[2] = hte_pkg::E_W'({job_q.lu, {F{1'b0}}}) + hte_pkg::E_W'(t2);
    e_d[3] = hte_pkg::E_W'({job_q.ll, {F{1'b0}}}) + hte_pkg::E_W'(t1_q);

    a_x    = hte_pkg::MUL2_W'(mul_sel_q ? e_q[1] : e_q[0]);
    b_x    = hte_pkg::MUL2_W'(mul_sel_q ? e_q[2] : e_q[3]);
    a_part = mcnt_q[1] ? a_x[hte_pkg::MUL2_W-1:hte_pkg::MUL_W] : a_x[hte_pkg::MUL_W-1:0];
    b_part = mcnt_q[0] ? b_x[hte_pkg::MUL2_W-1:hte_pkg::MUL_W] : b_x[hte_pkg::MUL_W-1:0];
    pp_d   = hte_pkg::MUL2_W'(a_part) * hte_pkg::MUL2_W'(b_part);
    pidx   = mcnt_q[1:0] - 2'd1;
    pp_ext = hte_pkg::PROD_W'(pp_q);
    case (pidx)
      2'd0:    acc_add = pp_ext;
      2'd1:    acc_add = pp_ext << hte_pkg::MUL_W;
      2'd2:    acc_add = pp_ext << hte_pkg::MUL_W;
      default: acc_add = pp_ext << hte_pkg::MUL2_W;
    endcase
    acc_d    = acc_q + acc_add;
    mul_last = (mcnt_q == 3'd4);

    sum  = hte_pkg::SUM_W'(cis_q) + hte_pkg::SUM_W'(acc_q);
    diff = (nxt_q > share_q) ? nxt_q - share_q : share_q - nxt_q;
    conv = ((hte_pkg::CMP_W'(diff) << hte_pkg::TOL_SCALE)
            < (hte_pkg::CMP_W'(tol_i) << F));
    last_iter = ((iter_q + 1'b1) == limit_i);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      hte_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          state_d = job_i.empty ? hte_pkg::ST_RES : hte_pkg::ST_T1;
        end
      end
      hte_pkg::ST_T1: state_d = hte_pkg::ST_EXP;
      hte_pkg::ST_EXP: state_d = freq_ph_q ? hte_pkg::ST_FDIV : hte_pkg::ST_MUL;
      hte_pkg::ST_MUL: begin
        if (mul_last && mul_sel_q) begin
          state_d = hte_pkg::ST_SUM;
        end
      end
      hte_pkg::ST_SUM: state_d = (sum == '0) ? hte_pkg::ST_CHK : hte_pkg::ST_EDIV;
      hte_pkg::ST_EDIV: begin
        if (div_done) begin
          state_d = hte_pkg::ST_CHK;
        end
      end
      hte_pkg::ST_CHK: state_d = hte_pkg::ST_T1;
      hte_pkg::ST_FDIV: begin
        if (div_done && (fidx_q == 2'd3)) begin
          state_d = hte_pkg::ST_RES;
        end
      end
      hte_pkg::ST_RES: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = hte_pkg::ST_IDLE;
        end
      end
      default: state_d = hte_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    job_ready_o   = (state_q == hte_pkg::ST_IDLE);
    pop           = job_ready_o && job_valid_i;
    res_load      = (state_q == hte_pkg::ST_RES) && (!out_valid_q || out_o.ready);
    em_div        = (state_q == hte_pkg::ST_SUM);
    fsel          = (state_q == hte_pkg::ST_EXP) ? 2'd0 : fidx_q + 2'd1;
    fnum          = (state_q == hte_pkg::ST_EXP) ? e_d[0] : e_q[fsel];
    div_req.start = (em_div && (sum != '0))
                  || ((state_q == hte_pkg::ST_EXP) && freq_ph_q)
                  || ((state_q == hte_pkg::ST_FDIV) && div_done && (fidx_q != 2'd3));
    div_req.steps = em_div ? hte_pkg::QBITS_W'(hte_pkg::SHARE_W)
                           : hte_pkg::QBITS_W'(hte_pkg::FREQ_W);
    if (em_div) begin
      div_num = hte_pkg::DIV_W'({cis_q, {F{1'b0}}});
      div_den = hte_pkg::DIV_W'({sum, {F{1'b0}}});
    end else begin
      div_num = hte_pkg::DIV_W'({fnum, {hte_pkg::FREQ_SHIFT{1'b0}}});
      div_den = hte_pkg::DIV_W'({job_q.tot, {(F + hte_pkg::FREQ_SHIFT){1'b0}}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hte_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      hte_pkg::ST_IDLE: begin
        if (pop) begin
          job_q  <= job_i;
          iter_q <= '0;
          if (job_i.h == '0) begin
            share_q   <= '0;
            stuck_q   <= 1'b0;
            freq_ph_q <= 1'b1;
          end else begin
            share_q   <= hte_pkg::SHARE_W'(1) << (F - 1);
            stuck_q   <= 1'b1;
            freq_ph_q <= (limit_i == '0);
          end
        end
      end
      hte_pkg::ST_T1: begin
        t1_q <= hte_pkg::T_W'(job_q.h) * hte_pkg::T_W'(share_q);
      end
      hte_pkg::ST_EXP: begin
        e_q       <= e_d;
        mcnt_q    <= '0;
        mul_sel_q <= 1'b0;
        acc_q     <= '0;
        fidx_q    <= '0;
      end
      hte_pkg::ST_MUL: begin
        pp_q <= pp_d;
        if (mul_last) begin
          mcnt_q <= '0;
          if (!mul_sel_q) begin
            cis_q     <= acc_d;
            acc_q     <= '0;
            mul_sel_q <= 1'b1;
          end else begin
            acc_q <= acc_d;
          end
        end else begin
          mcnt_q <= mcnt_q + 3'd1;
          if (mcnt_q != 3'd0) begin
            acc_q <= acc_d;
          end
        end
      end
      hte_pkg::ST_SUM: begin
        if (sum == '0) begin
          nxt_q <= share_q;
        end
      end
      hte_pkg::ST_EDIV: begin
        if (div_done) begin
          nxt_q <= div_quot;
        end
      end
      hte_pkg::ST_CHK: begin
        share_q <= nxt_q;
        iter_q  <= iter_q + 1'b1;
        if (conv) begin
          stuck_q   <= 1'b0;
          freq_ph_q <= 1'b1;
        end else if (last_iter) begin
          freq_ph_q <= 1'b1;
        end
      end
      hte_pkg::ST_FDIV: begin
        if (div_done) begin
          freq_q[fidx_q] <= div_quot[hte_pkg::FREQ_W-1:0];
          fidx_q         <= fidx_q + 2'd1;
        end
      end
      default: begin
      end
    endcase
    if (res_load) begin
      for (int k = 0; k < hte_pkg::NUM_HAP; k++) begin
        out_freq_q[k] <= job_q.empty ? '0 : freq_q[k];
      end
      out_stuck_q <= !job_q.empty && stuck_q;
      out_empty_q <= job_q.empty;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.freq_upper_upper = out_freq_q[0];
  assign out_o.freq_upper_lower = out_freq_q[1];
  assign out_o.freq_lower_upper = out_freq_q[2];
  assign out_o.freq_lower_lower = out_freq_q[3];
  assign out_o.not_converged    = out_stuck_q;
  assign out_o.empty_input      = out_empty_q;

endmodule

// ===== design/two_locus_haplotype_em_top.sv =====
// Top level of the two-locus haplotype EM block: register file, front stage, queue, engine.
// Depends on hte_pkg, hte_if, hte_front, hte_queue and hte_back.
//
// Use: one word on in_i carries the nine genotype counts of a 3x3 table; one word on out_o
// returns the four haplotype frequencies (unsigned Q1.16) and the two flags. cfg_i writes
// register 0 (iteration limit) and register 1 (tolerance); it is always ready, and the user must
// write it only while the block holds no word in flight; the block itself does not enforce this.
// Each EM step takes two four-piece products on the shared multiplier and, unless their
// sum is zero, a pass through the shared bit-serial divider; the four frequencies take
// one pass each on that divider.
// One table is worked at a time; the front stage and a two-word queue take further tables
// meanwhile, and the result register holds a finished word while the next table runs.
// When the receiver stalls, the result waits in its register and the engine waits after the
// next table is done; the front side fills and then drops in_i.ready.
// Reset clears all handshakes and loads the limit with 100 and the tolerance with 17.
`timescale 1ns / 1ps

module two_locus_haplotype_em_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  hte_in_if.sink    in_i,
  hte_out_if.source out_o,
  hte_cfg_if.sink   cfg_i
);

  logic [hte_pkg::LIMIT_W-1:0] limit_q;
  logic [hte_pkg::TOL_W-1:0]   tol_q;
  logic                        fr_valid, fr_ready, bk_valid, bk_ready;
  hte_pkg::job_t               fr_job, bk_job;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= hte_pkg::LIMIT_RESET;
      tol_q   <= hte_pkg::TOL_RESET;
    end else if (cfg_i.valid) begin
      case (hte_pkg::cfg_reg_e'(cfg_i.index))
        hte_pkg::REG_LIMIT: limit_q <= cfg_i.data[hte_pkg::LIMIT_W-1:0];
        hte_pkg::REG_TOL:   tol_q   <= cfg_i.data[hte_pkg::TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hte_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready),
    .job_o       (fr_job)
  );

  hte_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_job_i   (fr_job),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_job_o    (bk_job)
  );

  hte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (bk_valid),
    .job_ready_o (bk_ready),
    .job_i       (bk_job),
    .limit_i     (limit_q),
    .tol_i       (tol_q),
    .out_o       (out_o)
  );

`ifndef SYNTH
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.empty_input |->
      out_o.freq_upper_upper == '0 && out_o.freq_upper_lower == '0 &&
      out_o.freq_lower_upper == '0 && out_o.freq_lower_lower == '0 &&
      !out_o.not_converged)
    else $error("empty table gave nonzero result");

  a_freq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      out_o.freq_upper_upper <= 17'h10000 && out_o.freq_upper_lower <= 17'h10000 &&
      out_o.freq_lower_upper <= 17'h10000 && out_o.freq_lower_lower <= 17'h10000)
    else $error("frequency above one");

  a_queue_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fr_ready |-> bk_valid)
    else $error("queue full but reports no word");
`endif

endmodule
